/* src/mfde_pkg.sv */
`default_nettype none
package mfde_pkg;

	// Coordinate widths: wide enough for origin + extent of any command
	localparam int XW = 9;
	localparam int YW = 8;

	localparam int READ_BITS = 64;
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 72;

	typedef enum logic [2:0] {
		FUNC_CLEAR       = 3'd0,
		FUNC_PIXEL       = 3'd1,
		FUNC_OUTLINE     = 3'd2,
		FUNC_FILL        = 3'd3,
		FUNC_BLIT_START  = 3'd4,
		FUNC_BLIT_BYTE   = 3'd5,
		FUNC_READ        = 3'd6,
		FUNC_NOP         = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_CLIPPED = 2'd1,
		STATUS_NO_BLIT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		func_t       func;
		logic [6:0]  x_pos;
		logic [5:0]  y_pos;
		logic [7:0]  width;
		logic [6:0]  height;
		logic        fg_color;
		logic        bg_color;
		logic [7:0]  bitmap_byte;
	} cmd_t;

	typedef struct packed {
		logic          has_rows;
		logic          writes;
		logic          read_back;
		logic          clear;
		logic          outline;
		logic          upper_half;
		logic [YW-1:0] first_row;
		logic [YW-1:0] last_row;
		logic [YW-1:0] bottom_row;
		status_t       status;
	} plan_t;

	typedef struct packed {
		logic [READ_BITS-1:0] read_data;
		status_t              status;
	} result_t;

endpackage
`default_nettype wire

/* src/mfde_ram.sv */
`default_nettype none
module mfde_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/mfde_plan.sv */
`default_nettype none
module mfde_plan #(
	parameter int SCREEN_COLS = 128,
	parameter int SCREEN_ROWS = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire mfde_pkg::cmd_t         cmd,
	output      mfde_pkg::plan_t        plan,
	output      logic [SCREEN_COLS-1:0] span_mask,
	output      logic [SCREEN_COLS-1:0] edge_mask,
	output      logic [SCREEN_COLS-1:0] val_mask
);

	localparam int XW = mfde_pkg::XW;
	localparam int YW = mfde_pkg::YW;
	localparam logic [XW-1:0] COLS_X = XW'(SCREEN_COLS);
	localparam logic [YW-1:0] ROWS_Y = YW'(SCREEN_ROWS);
	localparam logic [XW-1:0] HALF_X = XW'(mfde_pkg::READ_BITS);
	localparam logic [SCREEN_COLS-1:0] ONE_COL = SCREEN_COLS'(1);

	// bitmap placement state
	logic [6:0] ox_q;
	logic [5:0] oy_q;
	logic [7:0] bw_q;
	logic [6:0] bh_q;
	logic [7:0] col_q;
	logic [6:0] row_q;
	logic [1:0] colors_q;

	logic [XW-1:0] x_c, x_last, blit_x, blit_x_last, blit_col_next, read_end;
	logic [YW-1:0] y_c, y_bottom, rows_last, blit_y;
	logic nonzero, blit_active, clip;
	logic [7:0] blit_left;
	logic [3:0] blit_cnt;
	logic [7:0] bits8, vals8;
	logic [SCREEN_COLS-1:0] run_mask;

	always_comb begin
		x_c       = XW'(cmd.x_pos);
		x_last    = x_c + XW'(cmd.width) - XW'(1);
		y_c       = YW'(cmd.y_pos);
		y_bottom  = y_c + YW'(cmd.height) - YW'(1);
		rows_last = (y_bottom >= ROWS_Y) ? ROWS_Y - YW'(1) : y_bottom;
		nonzero   = (cmd.width != 8'd0) && (cmd.height != 7'd0);
		read_end  = cmd.x_pos[6] ? HALF_X + HALF_X : HALF_X;

		blit_active   = (bw_q != 8'd0) && (row_q < bh_q);
		blit_x        = XW'(ox_q) + XW'(col_q);
		blit_left     = bw_q - col_q;
		blit_cnt      = (blit_left >= 8'd8) ? 4'd8 : blit_left[3:0];
		blit_x_last   = blit_x + XW'(blit_cnt) - XW'(1);
		blit_y        = YW'(oy_q) + YW'(row_q);
		blit_col_next = XW'(col_q) + XW'(8);

		for (int i = 0; i < 8; i++) begin
			bits8[i] = (4'(i) < blit_cnt);
			// MSB of the byte is the leftmost pixel
			vals8[i] = cmd.bitmap_byte[7-i] ? colors_q[0] : colors_q[1];
		end
		for (int c = 0; c < SCREEN_COLS; c++) begin
			run_mask[c] = (XW'(c) < XW'(cmd.width));
		end
	end

	always_comb begin
		plan            = '0;
		plan.first_row  = y_c;
		plan.last_row   = y_c;
		plan.bottom_row = y_bottom;
		plan.status     = mfde_pkg::STATUS_DONE;
		span_mask       = '0;
		edge_mask       = '0;
		val_mask        = {SCREEN_COLS{cmd.fg_color}};
		clip            = 1'b0;
		unique case (cmd.func)
			mfde_pkg::FUNC_CLEAR: begin
				plan.clear = 1'b1;
			end
			mfde_pkg::FUNC_PIXEL: begin
				plan.has_rows = (y_c < ROWS_Y);
				plan.writes   = 1'b1;
				span_mask     = ONE_COL << x_c;
				clip          = (x_c >= COLS_X) || (y_c >= ROWS_Y);
			end
			mfde_pkg::FUNC_OUTLINE, mfde_pkg::FUNC_FILL: begin
				plan.has_rows = nonzero && (y_c < ROWS_Y);
				plan.writes   = 1'b1;
				plan.outline  = (cmd.func == mfde_pkg::FUNC_OUTLINE);
				plan.last_row = rows_last;
				span_mask     = run_mask << cmd.x_pos;
				edge_mask     = (ONE_COL << x_c) | (ONE_COL << x_last);
				clip          = nonzero && ((x_last >= COLS_X) || (y_bottom >= ROWS_Y));
			end
			mfde_pkg::FUNC_BLIT_START: begin
			end
			mfde_pkg::FUNC_BLIT_BYTE: begin
				if (blit_active) begin
					plan.has_rows  = (blit_y < ROWS_Y);
					plan.writes    = 1'b1;
					plan.first_row = blit_y;
					plan.last_row  = blit_y;
					span_mask      = SCREEN_COLS'(bits8) << blit_x;
					val_mask       = SCREEN_COLS'(vals8) << blit_x;
					clip           = (blit_x_last >= COLS_X) || (blit_y >= ROWS_Y);
				end
			end
			mfde_pkg::FUNC_READ: begin
				plan.has_rows   = (y_c < ROWS_Y);
				plan.read_back  = 1'b1;
				plan.upper_half = cmd.x_pos[6];
				clip            = (y_c >= ROWS_Y) || (read_end > COLS_X);
			end
			mfde_pkg::FUNC_NOP: begin
			end
			default: begin
			end
		endcase
		if (cmd.func == mfde_pkg::FUNC_BLIT_BYTE && !blit_active) begin
			plan.status = mfde_pkg::STATUS_NO_BLIT;
		end else if (clip) begin
			plan.status = mfde_pkg::STATUS_CLIPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q     <= '0;
			oy_q     <= '0;
			bw_q     <= '0;
			bh_q     <= '0;
			col_q    <= '0;
			row_q    <= '0;
			colors_q <= '0;
		end else if (accept) begin
			if (cmd.func == mfde_pkg::FUNC_BLIT_START) begin
				ox_q     <= cmd.x_pos;
				oy_q     <= cmd.y_pos;
				bw_q     <= cmd.width;
				bh_q     <= cmd.height;
				col_q    <= '0;
				row_q    <= '0;
				colors_q <= {cmd.bg_color, cmd.fg_color};
			end else if (cmd.func == mfde_pkg::FUNC_BLIT_BYTE && blit_active) begin
				if (blit_col_next >= XW'(bw_q)) begin
					col_q <= '0;
					row_q <= row_q + 7'd1;
				end else begin
					col_q <= blit_col_next[7:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

/* src/mfde_sweep.sv */
`default_nettype none
module mfde_sweep #(
	parameter int SCREEN_COLS = 128,
	parameter int SCREEN_ROWS = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire mfde_pkg::plan_t        plan_in,
	input  wire logic [SCREEN_COLS-1:0] span_in,
	input  wire logic [SCREEN_COLS-1:0] edge_in,
	input  wire logic [SCREEN_COLS-1:0] val_in,
	output      logic                   idle,
	output      logic                   res_valid,
	input  wire logic                   res_ack,
	output      mfde_pkg::result_t      res
);

	localparam int AW = $clog2(SCREEN_ROWS);
	localparam int YW = mfde_pkg::YW;
	localparam int RB = mfde_pkg::READ_BITS;
	localparam logic [6:0] HALF_SHIFT = 7'(RB);

	mfde_pkg::state_t state_q, state_d;
	mfde_pkg::plan_t  plan_q;
	logic [SCREEN_COLS-1:0] span_q, edge_q, val_q;
	logic [YW-1:0] rd_row_q, row_s1;
	logic valid_s1;
	logic [SCREEN_ROWS-1:0] row_valid_q;
	mfde_pkg::result_t res_q;

	logic ram_re, ram_we, full_row;
	logic [SCREEN_COLS-1:0] rdata, old_row, mask, new_row;
	logic [SCREEN_COLS+RB-1:0] ext_row, ext_shift;

	mfde_ram #(
		.WIDTH(SCREEN_COLS),
		.DEPTH(SCREEN_ROWS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(row_s1[AW-1:0]),
		.wdata(new_row),
		.re   (ram_re),
		.raddr(rd_row_q[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfde_pkg::ST_IDLE: begin
				if (start) begin
					state_d = plan_in.has_rows ? mfde_pkg::ST_SWEEP : mfde_pkg::ST_DONE;
				end
			end
			mfde_pkg::ST_SWEEP: begin
				if (rd_row_q == plan_q.last_row) begin
					state_d = mfde_pkg::ST_DRAIN;
				end
			end
			mfde_pkg::ST_DRAIN: begin
				state_d = mfde_pkg::ST_DONE;
			end
			mfde_pkg::ST_DONE: begin
				if (res_ack) begin
					state_d = mfde_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mfde_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		idle      = (state_q == mfde_pkg::ST_IDLE);
		ram_re    = (state_q == mfde_pkg::ST_SWEEP);
		res_valid = (state_q == mfde_pkg::ST_DONE);
	end

	// read-modify-write stage; rows never written read as blank
	always_comb begin
		old_row   = row_valid_q[row_s1[AW-1:0]] ? rdata : '0;
		full_row  = !plan_q.outline || (row_s1 == plan_q.first_row) ||
		            (row_s1 == plan_q.bottom_row);
		mask      = full_row ? span_q : edge_q;
		new_row   = (old_row & ~mask) | (val_q & mask);
		ram_we    = valid_s1 && plan_q.writes;
		ext_row   = {{RB{1'b0}}, old_row};
		ext_shift = ext_row >> (plan_q.upper_half ? HALF_SHIFT : 7'd0);
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mfde_pkg::ST_IDLE;
			valid_s1    <= 1'b0;
			rd_row_q    <= '0;
			row_valid_q <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= ram_re;
			if (start) begin
				rd_row_q <= plan_in.first_row;
			end else if (ram_re) begin
				rd_row_q <= rd_row_q + YW'(1);
			end
			if (start && plan_in.clear) begin
				row_valid_q <= '0;
			end else if (ram_we) begin
				row_valid_q[row_s1[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= rd_row_q;
		if (start) begin
			plan_q            <= plan_in;
			span_q            <= span_in;
			edge_q            <= edge_in;
			val_q             <= val_in;
			res_q.status      <= plan_in.status;
			res_q.read_data   <= '0;
		end else if (valid_s1 && plan_q.read_back) begin
			res_q.read_data <= ext_shift[RB-1:0];
		end
	end

`ifndef SYNTHESIS
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mfde_pkg::ST_SWEEP |-> rd_row_q <= plan_q.last_row)
		else $error("sweep row ran past last row");
	a_no_rw_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> row_s1[AW-1:0] != rd_row_q[AW-1:0])
		else $error("read and write of the same row in one cycle");
	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !valid_s1)
		else $error("result offered while a row is still in flight");
	a_drain_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mfde_pkg::ST_DRAIN |=> state_q == mfde_pkg::ST_DONE)
		else $error("drain did not end in done");
`endif

endmodule
`default_nettype wire

/* src/mono_framebuffer_draw_engine.sv */
// One-bit framebuffer of SCREEN_COLS x SCREEN_ROWS pixels with a small drawing engine.
// Slave channel (s_*): one drawing command per request; s_tuser carries the command
// code, s_tdata its operands. Master channel (m_*): exactly one result per command,
// the read half row and a status code, in command order.
// Pixels live in one row-wide RAM; each touched row gets one masked read-modify-write,
// issued back to back; after the write of the last row drains, the result is offered
// to the output register. Clear, bitmap start and commands that touch no row skip the
// sweep and go straight to the result. The row sweep sets the command rate: the next
// command is taken once the result has moved into the output register, so one command
// is in work at a time.
// Clear resets every per-row valid flag as it is accepted; rows whose flag is low read
// as blank, so no clearing pass is run.
// Reset (arst_n low) clears the valid flags, the bitmap placement and all handshake
// state; the block is ready for a command as soon as reset is released.
// A finished result sits in an output register; while the receiver stalls the block
// still accepts and works on the next command, and holds its result back until the
// output register is taken.
`default_nettype none
module mono_framebuffer_draw_engine #(
	parameter int SCREEN_COLS = 128,
	parameter int SCREEN_ROWS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	// x_pos[6:0], y_pos[12:7], width[20:13], height[27:21], fg_color[28],
	// bg_color[29], bitmap_byte[37:30], zero[39:38]
	input  wire logic [mfde_pkg::S_TDATA_W-1:0] s_tdata,
	// func[2:0]
	input  wire logic [mfde_pkg::S_TUSER_W-1:0] s_tuser,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	// read_data[63:0], status[65:64], zero[71:66]
	output      logic [mfde_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int PAD_W = mfde_pkg::M_TDATA_W - mfde_pkg::READ_BITS - 2;

	mfde_pkg::cmd_t    cmd;
	mfde_pkg::plan_t   plan;
	mfde_pkg::result_t res, out_res_q;
	logic [SCREEN_COLS-1:0] span_mask, edge_mask, val_mask;
	logic accept, idle, res_valid, res_ack, out_valid_q;

	// unpack the request
	always_comb begin
		cmd.func        = mfde_pkg::func_t'(s_tuser);
		cmd.x_pos       = s_tdata[6:0];
		cmd.y_pos       = s_tdata[12:7];
		cmd.width       = s_tdata[20:13];
		cmd.height      = s_tdata[27:21];
		cmd.fg_color    = s_tdata[28];
		cmd.bg_color    = s_tdata[29];
		cmd.bitmap_byte = s_tdata[37:30];
	end

	assign s_tready = idle;
	assign accept   = s_tvalid && s_tready;

	// decode: shape masks, row span, clipping status; owns the bitmap cursor
	mfde_plan #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_plan (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.plan     (plan),
		.span_mask(span_mask),
		.edge_mask(edge_mask),
		.val_mask (val_mask)
	);

	// row sweep over the pixel RAM
	mfde_sweep #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.plan_in  (plan),
		.span_in  (span_mask),
		.edge_in  (edge_mask),
		.val_in   (val_mask),
		.idle     (idle),
		.res_valid(res_valid),
		.res_ack  (res_ack),
		.res      (res)
	);

	// output register: free, or emptied in this cycle
	assign res_ack = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ack) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_res_q.status, out_res_q.read_data};

endmodule
`default_nettype wire

/* dv/testbench.sv */
`default_nettype none
module testbench;

	localparam int COLS            = 128;
	localparam int ROWS            = 64;
	localparam int RANDOM_ITEMS    = 1100;
	localparam int LONG_HOLD       = 400;
	localparam int SETTLE_CYCLES   = 100;
	localparam int WATCHDOG_CYCLES = 4000;

	typedef struct packed {
		mfde_pkg::cmd_t    cmd;
		bit                known;
		logic [63:0]       data;
		mfde_pkg::status_t status;
	} step_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [mfde_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [mfde_pkg::S_TUSER_W-1:0] s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [mfde_pkg::M_TDATA_W-1:0] m_tdata;

	// typed-in expectation travelling alongside the request on the bus
	bit                given_known = 1'b0;
	logic [63:0]       given_data = '0;
	mfde_pkg::status_t given_status = mfde_pkg::STATUS_DONE;

	// shadow of the framebuffer and bitmap placement
	bit [COLS-1:0] fb_rows [ROWS];
	bit [6:0]      blit_x;
	bit [5:0]      blit_y;
	bit [7:0]      blit_w;
	bit [6:0]      blit_h;
	bit [7:0]      blit_c;
	bit [6:0]      blit_r;
	bit            blit_fg;
	bit            blit_bg;

	mfde_pkg::result_t pending_results [$];
	step_t   directed [$];
	int      mismatches = 0;
	int      sent_items = 0;
	int      idle_cycles = 0;
	int      rx_wait = 0;
	int      hold_left = 0;
	bit      hold_req = 1'b0;
	bit      no_gaps = 1'b0;

	mono_framebuffer_draw_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic bit plot(int px, int py, bit v);
		if (px >= COLS || py >= ROWS)
			return 1'b1;
		fb_rows[py][px] = v;
		return 1'b0;
	endfunction

	// applies one drawing request to the shadow and returns its response
	function automatic mfde_pkg::result_t render_cmd(mfde_pkg::cmd_t c);
		mfde_pkg::result_t res;
		bit      clip;
		bit      fg;
		int      x, y, w, h, i, j, nxt;
		res.read_data = '0;
		res.status    = mfde_pkg::STATUS_DONE;
		clip = 1'b0;
		fg   = c.fg_color;
		x = c.x_pos;
		y = c.y_pos;
		w = c.width;
		h = c.height;
		case (c.func)
			mfde_pkg::FUNC_CLEAR: begin
				for (j = 0; j < ROWS; j++)
					fb_rows[j] = '0;
			end
			mfde_pkg::FUNC_PIXEL: clip = plot(x, y, fg);
			mfde_pkg::FUNC_OUTLINE: begin
				if (w != 0 && h != 0) begin
					for (i = 0; i < w; i++) begin
						clip |= plot(x + i, y, fg);
						clip |= plot(x + i, y + h - 1, fg);
					end
					for (j = 1; j < h; j++) begin
						clip |= plot(x, y + j, fg);
						clip |= plot(x + w - 1, y + j, fg);
					end
				end
			end
			mfde_pkg::FUNC_FILL: begin
				for (j = 0; j < h; j++)
					for (i = 0; i < w; i++)
						clip |= plot(x + i, y + j, fg);
			end
			mfde_pkg::FUNC_BLIT_START: begin
				blit_x  = c.x_pos;
				blit_y  = c.y_pos;
				blit_w  = c.width;
				blit_h  = c.height;
				blit_c  = '0;
				blit_r  = '0;
				blit_fg = c.fg_color;
				blit_bg = c.bg_color;
			end
			mfde_pkg::FUNC_BLIT_BYTE: begin
				if (blit_w == 0 || blit_r >= blit_h) begin
					res.status = mfde_pkg::STATUS_NO_BLIT;
				end else begin
					// MSB is the leftmost pixel; bits past the width fall away
					for (i = 0; i < 8 && int'(blit_c) + i < int'(blit_w); i++)
						clip |= plot(int'(blit_x) + int'(blit_c) + i,
							int'(blit_y) + int'(blit_r),
							c.bitmap_byte[7 - i] ? blit_fg : blit_bg);
					nxt = int'(blit_c) + 8;
					if (nxt >= int'(blit_w)) begin
						blit_c = '0;
						blit_r = blit_r + 7'd1;
					end else begin
						blit_c = nxt[7:0];
					end
				end
			end
			mfde_pkg::FUNC_READ: begin
				res.read_data = c.x_pos[6] ? fb_rows[c.y_pos][127:64] : fb_rows[c.y_pos][63:0];
			end
			default: ;
		endcase
		if (res.status == mfde_pkg::STATUS_DONE && clip)
			res.status = mfde_pkg::STATUS_CLIPPED;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("%0t mismatch in %s: got %h, want %h", $time, what, got, want);
	endtask

	// response check, request capture and watchdog, all on the rising edge
	always @(posedge clk) begin
		mfde_pkg::result_t want;
		mfde_pkg::cmd_t    c;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected response", m_tdata[63:0], '0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[63:0] !== want.read_data)
						report_mismatch("read_data", m_tdata[63:0], want.read_data);
					if (m_tdata[65:64] !== want.status)
						report_mismatch("status", 64'(m_tdata[65:64]), 64'(want.status));
				end
			end
			if (s_tvalid && s_tready) begin
				c.func        = mfde_pkg::func_t'(s_tuser);
				c.x_pos       = s_tdata[6:0];
				c.y_pos       = s_tdata[12:7];
				c.width       = s_tdata[20:13];
				c.height      = s_tdata[27:21];
				c.fg_color    = s_tdata[28];
				c.bg_color    = s_tdata[29];
				c.bitmap_byte = s_tdata[37:30];
				want = render_cmd(c);
				if (given_known) begin
					want.read_data = given_data;
					want.status    = given_status;
				end
				pending_results.push_back(want);
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t watchdog: no request or response moved", $time);
				$display("testbench failed");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random back-pressure, plus one long hold on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (no_gaps) begin
			m_tready <= 1'b1;
		end else if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
			rx_wait = pick_gap();
		end
	end

	function automatic mfde_pkg::cmd_t cmd_of(mfde_pkg::func_t f, int x, int y, int w, int h,
		bit fg, bit bg, int b);
		mfde_pkg::cmd_t c;
		c.func        = f;
		c.x_pos       = x[6:0];
		c.y_pos       = y[5:0];
		c.width       = w[7:0];
		c.height      = h[6:0];
		c.fg_color    = fg;
		c.bg_color    = bg;
		c.bitmap_byte = b[7:0];
		return c;
	endfunction

	function automatic mfde_pkg::cmd_t any_cmd(mfde_pkg::func_t f);
		mfde_pkg::cmd_t c;
		logic [63:0]    r;
		r = {$urandom, $urandom};
		c = r[$bits(mfde_pkg::cmd_t)-1:0];
		c.func = f;
		return c;
	endfunction

	function automatic step_t row_of(mfde_pkg::cmd_t c, bit known, logic [63:0] d,
		mfde_pkg::status_t s);
		step_t st;
		st.cmd    = c;
		st.known  = known;
		st.data   = d;
		st.status = s;
		return st;
	endfunction

	// offers one request, waits for it to be taken, then maybe idles
	task automatic send(mfde_pkg::cmd_t c, bit known = 1'b0, logic [63:0] d = '0,
		mfde_pkg::status_t s = mfde_pkg::STATUS_DONE);
		int g;
		@(negedge clk);
		s_tvalid     <= 1'b1;
		s_tuser      <= c.func;
		s_tdata      <= {2'b00, c.bitmap_byte, c.bg_color, c.fg_color, c.height,
			c.width, c.y_pos, c.x_pos};
		given_known  <= known;
		given_data   <= d;
		given_status <= s;
		@(posedge clk);
		while (!(s_tvalid && s_tready))
			@(posedge clk);
		sent_items++;
		g = no_gaps ? 0 : pick_gap();
		if (g > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// stops offering, then waits for every expected response
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic pick_rect(ref mfde_pkg::cmd_t c);
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			c.width  = 8'($urandom_range(0, 20));
			c.height = 7'($urandom_range(0, 12));
		end else if (r < 95) begin
			c.width  = 8'($urandom_range(0, 128));
			c.height = 7'($urandom_range(0, 64));
		end else begin
			c.width  = 8'($urandom_range(0, 255));
			c.height = 7'($urandom_range(0, 127));
		end
	endtask

	initial begin
		mfde_pkg::cmd_t c;
		int   target, r, bw, bh, nbytes, k;
		bit   held, paused;

		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 127, 63, 0, 0, 0, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_BYTE, 0, 0, 0, 0, 1, 1, 'hff), 1,
			'0, mfde_pkg::STATUS_NO_BLIT));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_PIXEL, 0, 0, 0, 0, 1, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_PIXEL, 127, 63, 0, 0, 1, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, 64'h1,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 64, 63, 0, 0, 0, 0, 0), 1,
			64'h8000_0000_0000_0000, mfde_pkg::STATUS_DONE));
		// whole screen set, then a maximal fill from the far corner
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_FILL, 0, 0, 128, 64, 1, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 0, 32, 0, 0, 0, 0, 0), 1, '1,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_FILL, 127, 63, 255, 127, 0, 0, 0), 1,
			'0, mfde_pkg::STATUS_CLIPPED));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 64, 63, 0, 0, 0, 0, 0), 1,
			64'h7fff_ffff_ffff_ffff, mfde_pkg::STATUS_DONE));
		// zero-size rectangles draw nothing
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_OUTLINE, 0, 0, 0, 5, 0, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_FILL, 3, 3, 5, 0, 0, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_OUTLINE, 2, 3, 10, 6, 1, 0, 0), 1, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_OUTLINE, 120, 60, 16, 8, 1, 0, 0), 1,
			'0, mfde_pkg::STATUS_CLIPPED));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 0, 8, 0, 0, 0, 0, 0), 0, '0,
			mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 64, 60, 0, 0, 0, 0, 0), 0, '0,
			mfde_pkg::STATUS_DONE));
		// bitmap at the bottom right corner, hanging off the right edge, two bytes per row
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_START, 124, 62, 12, 2, 1, 0, 0),
			1, '0, mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_BYTE, 0, 0, 0, 0, 0, 0, 'ha5), 1,
			'0, mfde_pkg::STATUS_CLIPPED));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_BYTE, 0, 0, 0, 0, 0, 0, 'hff), 1,
			'0, mfde_pkg::STATUS_CLIPPED));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_BYTE, 0, 0, 0, 0, 0, 0, 'h3c), 1,
			'0, mfde_pkg::STATUS_CLIPPED));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_BYTE, 0, 0, 0, 0, 0, 0, 'hc3), 1,
			'0, mfde_pkg::STATUS_CLIPPED));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_BYTE, 0, 0, 0, 0, 0, 0, 'h55), 1,
			'0, mfde_pkg::STATUS_NO_BLIT));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_READ, 64, 62, 0, 0, 0, 0, 0), 0, '0,
			mfde_pkg::STATUS_DONE));
		// a zero-width start leaves the bitmap inactive
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_START, 5, 5, 0, 4, 1, 1, 0), 1,
			'0, mfde_pkg::STATUS_DONE));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_BLIT_BYTE, 0, 0, 0, 0, 0, 0, 'h81), 1,
			'0, mfde_pkg::STATUS_NO_BLIT));
		directed.push_back(row_of(cmd_of(mfde_pkg::FUNC_NOP, 127, 63, 255, 127, 1, 1, 'hff), 1,
			'0, mfde_pkg::STATUS_DONE));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send(directed[i].cmd, directed[i].known, directed[i].data, directed[i].status);
		drain();

		target = sent_items + RANDOM_ITEMS;
		held   = 1'b0;
		paused = 1'b0;
		while (sent_items < target) begin
			if (!held && sent_items >= target - 800) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && sent_items >= target - 550) begin
				drain();
				paused = 1'b1;
			end
			no_gaps = (sent_items >= target - 400 && sent_items < target - 300);
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send(any_cmd(mfde_pkg::FUNC_PIXEL));
			end else if (r < 32) begin
				c = any_cmd(r < 22 ? mfde_pkg::FUNC_OUTLINE : mfde_pkg::FUNC_FILL);
				pick_rect(c);
				send(c);
			end else if (r < 52) begin
				// well-formed bitmap run, sometimes cut short or overrun
				r = $urandom_range(0, 99);
				if (r < 80) begin
					bw = $urandom_range(1, 24);
					bh = $urandom_range(1, 8);
				end else if (r < 95) begin
					bw = $urandom_range(25, 140);
					bh = $urandom_range(1, 3);
				end else begin
					bw = $urandom_range(0, 255);
					bh = $urandom_range(0, 2);
				end
				c = any_cmd(mfde_pkg::FUNC_BLIT_START);
				c.width  = 8'(bw);
				c.height = 7'(bh);
				send(c);
				nbytes = ((bw + 7) / 8) * bh;
				r = $urandom_range(0, 99);
				if (r < 10 && nbytes > 0)
					nbytes = $urandom_range(0, nbytes - 1);
				else if (r < 20)
					nbytes += $urandom_range(1, 2);
				for (k = 0; k < nbytes; k++) begin
					if ($urandom_range(0, 9) == 0)
						send(any_cmd(mfde_pkg::FUNC_READ));
					send(any_cmd(mfde_pkg::FUNC_BLIT_BYTE));
				end
			end else if (r < 82) begin
				send(any_cmd(mfde_pkg::FUNC_READ));
			end else if (r < 85) begin
				send(any_cmd(mfde_pkg::FUNC_CLEAR));
			end else if (r < 88) begin
				send(any_cmd(mfde_pkg::FUNC_NOP));
			end else begin
				send(any_cmd(mfde_pkg::func_t'($urandom_range(0, 7))));
			end
		end
		no_gaps = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
`default_nettype wire
